/* sv/kwm_pkg.sv */
// kwm_pkg: shared sizes, request/response types and helpers for the k-way merge.
// Used by kwm_qtab and k_way_sorted_merge; depends on nothing.
package kwm_pkg;

   localparam int LIST_COUNT  = 8;
   localparam int QUEUE_DEPTH = 16;

   localparam int LIST_W  = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRIES = LIST_COUNT * QUEUE_DEPTH;
   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam int DATA_W  = 32;

   typedef enum logic [1:0] {
      MODE_APPEND = 2'd0,
      MODE_POP    = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_NOP    = 2'd3
   } kwm_mode_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } kwm_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT,
      ST_FINISH
   } kwm_state_type;

   typedef struct packed {
      kwm_mode_type       mode;
      logic [2:0]         list_index;
      logic signed [31:0] value;
   } kwm_req_type;

   typedef struct packed {
      kwm_status_type     status;
      logic signed [31:0] min_value;
      logic [2:0]         source_list;
   } kwm_rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } kwm_qcmd_type;

   function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] cnt);
      logic [PTR_W:0] sum;
      sum = {1'b0, ptr} + (PTR_W+1)'(cnt);
      if (sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] res;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = ptr + PTR_W'(1);
      end
      return res;
   endfunction

   function automatic logic [ADDR_W-1:0] entry_addr(input logic [LIST_W-1:0] lst,
                                                   input logic [PTR_W-1:0] slot);
      return ADDR_W'(lst) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
   endfunction

endpackage

/* sv/kwm_ram.sv */
// kwm_ram: generic simple dual-port RAM, one write and one registered read port.
// No package dependency.
module kwm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/kwm_qtab.sv */
// kwm_qtab: per-list head pointer and fill count table with one indexed port.
// Depends on kwm_pkg.
module kwm_qtab (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [kwm_pkg::LIST_W-1:0]    idx,
   input  kwm_pkg::kwm_qcmd_type         cmd,
   output logic [kwm_pkg::PTR_W-1:0]     rd_ptr,
   output logic [kwm_pkg::CNT_W-1:0]     rd_cnt
);
   import kwm_pkg::*;

   logic [PTR_W-1:0] ptr_ff [LIST_COUNT];
   logic [CNT_W-1:0] cnt_ff [LIST_COUNT];

   assign rd_ptr = ptr_ff[idx];
   assign rd_cnt = cnt_ff[idx];

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < LIST_COUNT; i++) begin
            ptr_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
      end else if (cmd.push) begin
         cnt_ff[idx] <= rd_cnt + CNT_W'(1);
      end else if (cmd.pop) begin
         ptr_ff[idx] <= slot_inc(rd_ptr);
         cnt_ff[idx] <= rd_cnt - CNT_W'(1);
      end
   end

endmodule

/* sv/k_way_sorted_merge.sv */
// k_way_sorted_merge: top level, per-list FIFOs in one RAM, pop by head scan.
// Depends on kwm_pkg, kwm_ram and kwm_qtab.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_data (kwm_req_type)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_data (kwm_rsp_type)
//
// Append, clear and no-op requests go from IDLE to FINISH; a pop first runs SCAN,
// DRAIN and COMMIT; SCAN reads one queue head per cycle from the one RAM read port.
// Reset is synchronous and empties all queues at once; no clearing pass.
// A finished response waits in the output register while the next request is taken;
// a held rsp_stall keeps the following result in FINISH and so stalls new requests.
module k_way_sorted_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  kwm_pkg::kwm_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output kwm_pkg::kwm_rsp_type  rsp_data
);
   import kwm_pkg::*;

   localparam logic [6:0] LIST_LIMIT = 7'(LIST_COUNT);

   kwm_state_type state_ff, state_in;

   logic                 req_take;
   logic                 rsp_load;
   logic                 scan_last;
   logic [LIST_W-1:0]    req_list;
   logic                 req_oob;
   logic                 req_full;

   logic [LIST_W-1:0]    qt_idx;
   kwm_qcmd_type         qt_cmd;
   logic [PTR_W-1:0]     qt_ptr;
   logic [CNT_W-1:0]     qt_cnt;

   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic                 ram_rd_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [DATA_W-1:0]    ram_rd_data;

   logic [LIST_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [LIST_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                 best_found_ff, best_found_in;
   logic [LIST_W-1:0]    best_idx_ff, best_idx_in;
   logic signed [31:0]   best_val_ff, best_val_in;
   logic                 take_head;

   kwm_rsp_type          res_ff, res_in;
   kwm_rsp_type          rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   assign req_take  = req_valid && !req_stall;
   assign req_list  = LIST_W'(7'(req_data.list_index));
   assign req_oob   = 7'(req_data.list_index) >= LIST_LIMIT;
   assign req_full  = req_oob || (qt_cnt >= CNT_W'(QUEUE_DEPTH));
   assign scan_last = scan_idx_ff == LIST_W'(LIST_COUNT - 1);

   kwm_qtab u_qtab (
      .clock  (clock),
      .reset  (reset),
      .idx    (qt_idx),
      .cmd    (qt_cmd),
      .rd_ptr (qt_ptr),
      .rd_cnt (qt_cnt)
   );

   kwm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_data.value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.mode == MODE_POP) ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_FINISH;
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall   = 1'b1;
      rsp_load    = 1'b0;
      qt_idx      = scan_idx_ff;
      qt_cmd      = '0;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            qt_idx    = req_list;
            if (req_valid) begin
               unique case (req_data.mode)
                  MODE_APPEND: begin
                     qt_cmd.push = !req_full;
                     ram_wr_en   = !req_full;
                  end
                  MODE_CLEAR:  qt_cmd.clear = 1'b1;
                  MODE_POP,
                  MODE_NOP:    ;
                  default:     ;
               endcase
            end
         end
         ST_SCAN: begin
            qt_idx    = scan_idx_ff;
            ram_rd_en = qt_cnt != '0;
         end
         ST_DRAIN: ;
         ST_COMMIT: begin
            qt_idx     = best_idx_ff;
            qt_cmd.pop = best_found_ff;
         end
         ST_FINISH: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: ;
      endcase
   end

   assign ram_wr_addr = entry_addr(req_list, slot_add(qt_ptr, qt_cnt));
   assign ram_rd_addr = entry_addr(scan_idx_ff, qt_ptr);

   // scan datapath
   assign take_head = rd_vld_ff
                      && (!best_found_ff || ($signed(ram_rd_data) < best_val_ff));

   always_comb begin
      scan_idx_in   = scan_idx_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = scan_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_val_in   = best_val_ff;
      res_in        = res_ff;
      if (state_ff == ST_IDLE && req_take) begin
         scan_idx_in   = '0;
         best_found_in = 1'b0;
         res_in        = '{status: STAT_DONE, min_value: '0, source_list: '0};
         if (req_data.mode == MODE_APPEND && req_full) begin
            res_in.status = STAT_FULL;
         end
      end
      if (state_ff == ST_SCAN) begin
         rd_vld_in   = qt_cnt != '0;
         scan_idx_in = scan_idx_ff + LIST_W'(1);
      end
      if (take_head) begin
         best_found_in = 1'b1;
         best_idx_in   = rd_idx_ff;
         best_val_in   = $signed(ram_rd_data);
      end
      if (state_ff == ST_COMMIT) begin
         if (best_found_ff) begin
            res_in = '{status: STAT_DONE, min_value: best_val_ff,
                       source_list: 3'(7'(best_idx_ff))};
         end else begin
            res_in = '{status: STAT_EMPTY, min_value: '0, source_list: '0};
         end
      end
   end

   // output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         rd_vld_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         scan_idx_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_vld_ff     <= rd_vld_in;
         best_found_ff <= best_found_in;
         scan_idx_ff   <= scan_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
